[rtl/spq_pkg.sv]
package spq_pkg;

	// Field widths of the request and response
	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;
	localparam int OCC_W   = 5;
	localparam int STAT_W  = 2;

	// Defaults for the top level parameters
	localparam int CAPACITY_DEF      = 16;
	localparam int PRIORITY_BITS_DEF = 16;

	// Request types
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// Response status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

[rtl/spq_if.sv]
// Request channel: push or pop
interface spq_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic signed [spq_pkg::VALUE_W-1:0]  push_value;
	logic signed [spq_pkg::PRIO_W-1:0]   push_priority;

	modport source (output valid, req_type, push_value, push_priority, input ready);
	modport sink   (input valid, req_type, push_value, push_priority, output ready);
endinterface

// Response channel: one per request
interface spq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [spq_pkg::VALUE_W-1:0]  pop_data;
	logic        [spq_pkg::STAT_W-1:0]   status;
	logic        [spq_pkg::OCC_W-1:0]    occupancy;

	modport source (output valid, pop_data, status, occupancy, input ready);
	modport sink   (input valid, pop_data, status, occupancy, output ready);
endinterface

[rtl/sorted_priority_queue.sv]
// Bounded priority queue built as a row of CAPACITY compare-and-shift cells
// kept in descending priority order. A push inserts ahead of every entry of
// the same or lower priority, so a pop returns the greatest priority, newest
// first among equals. All cells update in parallel on the accepting edge and
// the response sits in an output register the cycle after, so requests go
// through one per cycle while the response side keeps up. Pop on empty
// answers status 1, push on full answers status 2 and drops the item;
// occupancy is the count after the request, taken modulo 32.
module sorted_priority_queue #(
	parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int KEY_W = (PRIORITY_BITS < spq_pkg::PRIO_W) ? PRIORITY_BITS : spq_pkg::PRIO_W;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [KEY_W-1:0] KEY_SIGN = KEY_W'(1) << (KEY_W - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	logic                         rsp_valid_q;
	logic [spq_pkg::VALUE_W-1:0]  pop_data_q;
	logic [spq_pkg::STAT_W-1:0]   status_q;
	logic [spq_pkg::OCC_W-1:0]    occupancy_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_d;

	logic                         accept;
	logic                         is_pop;
	logic                         full;
	logic                         empty;
	logic [KEY_W-1:0]             new_key;
	spq_pkg::cell_ctrl_t          ctrl;

	logic                         cell_valid [CAPACITY];
	logic [spq_pkg::VALUE_W-1:0]  cell_value [CAPACITY];
	logic [KEY_W-1:0]             cell_key   [CAPACITY];
	logic                         cell_stays [CAPACITY];
	logic [CAPACITY-1:0]          valid_vec;

	// Handshake and request decode
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_pop    = (req.req_type == spq_pkg::REQ_POP);
	assign full      = (count_q == CNT_FULL);
	assign empty     = (count_q == '0);

	// Order key: two's complement priority with the sign bit flipped
	assign new_key = req.push_priority[KEY_W-1:0] ^ KEY_SIGN;

	assign ctrl.push = accept && !is_pop && !full;
	assign ctrl.pop  = accept && is_pop && !empty;

	// Cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                         p_stays;
		logic                         p_valid;
		logic [spq_pkg::VALUE_W-1:0]  p_value;
		logic [KEY_W-1:0]             p_key;
		logic                         n_valid;
		logic [spq_pkg::VALUE_W-1:0]  n_value;
		logic [KEY_W-1:0]             n_key;

		if (i == 0) begin : g_head
			assign p_stays = 1'b1;
			assign p_valid = 1'b0;
			assign p_value = '0;
			assign p_key   = '0;
		end else begin : g_mid
			assign p_stays = cell_stays[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_value = cell_value[i-1];
			assign p_key   = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_value = '0;
			assign n_key   = '0;
		end else begin : g_body
			assign n_valid = cell_valid[i+1];
			assign n_value = cell_value[i+1];
			assign n_key   = cell_key[i+1];
		end

		spq_cell #(
			.KEY_W (KEY_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_value  (req.push_value),
			.new_key    (new_key),
			.prev_stays (p_stays),
			.prev_valid (p_valid),
			.prev_value (p_value),
			.prev_key   (p_key),
			.next_valid (n_valid),
			.next_value (n_value),
			.next_key   (n_key),
			.valid      (cell_valid[i]),
			.value      (cell_value[i]),
			.key        (cell_key[i]),
			.stays      (cell_stays[i])
		);

		assign valid_vec[i] = cell_valid[i];
	end

	// Entry count
	always_comb begin
		count_d = count_q;
		if (ctrl.push) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (accept) begin
			occupancy_q <= spq_pkg::OCC_W'(count_d);
			pop_data_q  <= ctrl.pop ? cell_value[0] : '0;
			if (is_pop) begin
				status_q <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
			end else begin
				status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pop_data  = pop_data_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occupancy_q;

	// Occupied cells always equal the count
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'($countones(valid_vec)) == count_q)
		else $error("cell valid bits disagree with entry count");

	// A non-empty queue has its head cell occupied
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> cell_valid[0])
		else $error("non-empty queue with empty head cell");

	// An accepted request always yields a response next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("request accepted without a response");

	// A held response is not overwritten by a new request
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |-> !accept)
		else $error("request accepted while response stalled");

endmodule

[rtl/spq_cell.sv]
// One slot of the sorted row. Cell 0 holds the greatest priority.
module spq_cell #(
	parameter int KEY_W = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spq_pkg::cell_ctrl_t          ctrl,
	input  logic [spq_pkg::VALUE_W-1:0]  new_value,
	input  logic [KEY_W-1:0]             new_key,
	input  logic                         prev_stays,
	input  logic                         prev_valid,
	input  logic [spq_pkg::VALUE_W-1:0]  prev_value,
	input  logic [KEY_W-1:0]             prev_key,
	input  logic                         next_valid,
	input  logic [spq_pkg::VALUE_W-1:0]  next_value,
	input  logic [KEY_W-1:0]             next_key,
	output logic                         valid,
	output logic [spq_pkg::VALUE_W-1:0]  value,
	output logic [KEY_W-1:0]             key,
	output logic                         stays
);

	logic                         valid_q;
	logic [spq_pkg::VALUE_W-1:0]  value_q;
	logic [KEY_W-1:0]             key_q;
	logic                         valid_d;
	logic [spq_pkg::VALUE_W-1:0]  value_d;
	logic [KEY_W-1:0]             key_d;

	// Entry keeps its slot on push when it outranks the new one
	assign stays = valid_q && (key_q > new_key);

	// Next slot contents
	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		key_d   = key_q;
		if (ctrl.pop) begin
			valid_d = next_valid;
			value_d = next_value;
			key_d   = next_key;
		end else if (ctrl.push && !stays) begin
			if (prev_stays) begin
				valid_d = 1'b1;
				value_d = new_value;
				key_d   = new_key;
			end else begin
				valid_d = prev_valid;
				value_d = prev_value;
				key_d   = prev_key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		key_q   <= key_d;
	end

	assign valid = valid_q;
	assign value = value_q;
	assign key   = key_q;

endmodule

[bench/sorted_priority_queue_tb.sv]
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

	localparam int QUEUE_DEPTH = spq_pkg::CAPACITY_DEF;
	localparam int TOTAL_REQS  = 1800;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;
	localparam int LONG_HOLD   = 100;

	typedef struct {
		logic                                kind;
		logic signed [spq_pkg::VALUE_W-1:0]  value;
		logic signed [spq_pkg::PRIO_W-1:0]   prio;
		bit                                  drain_first;
	} request_t;

	typedef struct {
		logic signed [spq_pkg::VALUE_W-1:0]  value;
		logic        [spq_pkg::STAT_W-1:0]   status;
		logic        [spq_pkg::OCC_W-1:0]    occ;
	} response_t;

	logic clk;
	logic arst_n;

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Requests waiting to be sent and responses waiting to arrive
	request_t  pending_reqs[$];
	response_t awaited_rsps[$];

	// Shadow copy of the sorted list, lowest priority in slot 0
	logic signed [spq_pkg::VALUE_W-1:0] shadow_value[QUEUE_DEPTH];
	logic signed [spq_pkg::PRIO_W-1:0]  shadow_prio[QUEUE_DEPTH];
	int                                 shadow_count = 0;

	int          mismatches  = 0;
	int          checked     = 0;
	int          push_count  = 0;
	int          pop_count   = 0;
	int          full_count  = 0;
	int          empty_count = 0;
	int          peak_occ    = 0;
	int unsigned cycle_count = 0;

	// Apply one request to the shadow list and return the response it should produce
	function automatic response_t apply_to_shadow_queue(request_t r);
		response_t rsp;
		int        pos;
		rsp.value  = '0;
		rsp.status = spq_pkg::ST_OK;
		if (r.kind == spq_pkg::REQ_PUSH) begin
			push_count++;
			if (shadow_count >= QUEUE_DEPTH) begin
				rsp.status = spq_pkg::ST_FULL;
				full_count++;
			end else begin
				// new entry goes above every entry of same or lower priority
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] <= r.prio)
					pos++;
				for (int i = shadow_count; i > pos; i--) begin
					shadow_value[i] = shadow_value[i-1];
					shadow_prio[i]  = shadow_prio[i-1];
				end
				shadow_value[pos] = r.value;
				shadow_prio[pos]  = r.prio;
				shadow_count++;
				if (shadow_count > peak_occ)
					peak_occ = shadow_count;
			end
		end else begin
			pop_count++;
			if (shadow_count == 0) begin
				rsp.status = spq_pkg::ST_EMPTY;
				empty_count++;
			end else begin
				shadow_count--;
				rsp.value = shadow_value[shadow_count];
			end
		end
		rsp.occ = shadow_count[spq_pkg::OCC_W-1:0];
		return rsp;
	endfunction

	task automatic report_mismatch(string what, longint exp_v, longint got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] response %0d: %s expected %0d, got %0d",
				$time, checked, what, exp_v, got_v);
	endtask

	function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
		logic signed [spq_pkg::PRIO_W-1:0] p;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: p = spq_pkg::PRIO_W'($urandom_range(0, 6) - 3);  // many ties
			6:                p = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default:          p = spq_pkg::PRIO_W'($urandom());
		endcase
		return p;
	endfunction

	task automatic add_req(logic kind, logic signed [spq_pkg::VALUE_W-1:0] value,
			logic signed [spq_pkg::PRIO_W-1:0] prio, bit drain_first);
		request_t r;
		r.kind        = kind;
		r.value       = value;
		r.prio        = prio;
		r.drain_first = drain_first;
		pending_reqs.push_back(r);
	endtask

	// Request driver: bursts of random length separated by random gaps
	int burst_left;
	int gap_left;
	bit tx_busy;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid         <= 1'b0;
			req_ch.req_type      <= spq_pkg::REQ_PUSH;
			req_ch.push_value    <= '0;
			req_ch.push_priority <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			tx_busy = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				awaited_rsps.push_back(apply_to_shadow_queue(pending_reqs[0]));
				pending_reqs.pop_front();
				tx_busy = 1'b0;
			end
			if (!tx_busy) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() == 0 ||
						(pending_reqs[0].drain_first && awaited_rsps.size() != 0)) begin
					req_ch.valid <= 1'b0;
				end else begin
					req_ch.valid         <= 1'b1;
					req_ch.req_type      <= pending_reqs[0].kind;
					req_ch.push_value    <= pending_reqs[0].value;
					req_ch.push_priority <= pending_reqs[0].prio;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Response monitor and receiver stall pattern
	int hold_left;
	int stall_mode;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left  = 0;
			stall_mode = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				checked++;
				if (awaited_rsps.size() == 0) begin
					report_mismatch("unexpected response, value", 0, rsp_ch.pop_data);
				end else begin
					if (rsp_ch.pop_data !== awaited_rsps[0].value)
						report_mismatch("pop_data", awaited_rsps[0].value,
							rsp_ch.pop_data);
					if (rsp_ch.status !== awaited_rsps[0].status)
						report_mismatch("status", awaited_rsps[0].status, rsp_ch.status);
					if (rsp_ch.occupancy !== awaited_rsps[0].occ)
						report_mismatch("occupancy", awaited_rsps[0].occ, rsp_ch.occupancy);
					awaited_rsps.pop_front();
				end
			end

			cycle_count++;
			if (cycle_count % 50 == 0)
				stall_mode = $urandom_range(0, 3);
			// long hold-offs so the block backs up into the request side
			if (cycle_count == 300 || cycle_count == 2500)
				hold_left = LONG_HOLD;

			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0:       rsp_ch.ready <= 1'b1;
					1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
					2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= cycle_count[1];
				endcase
			end
		end
	end

	int push_pct;

	initial begin
		arst_n = 1'b0;

		// Directed: pop on empty, field extremes, ties, fill to full, push on full
		add_req(spq_pkg::REQ_POP,  32'sh1234_5678, 16'sh0000, 1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sh7fff_ffff, 16'sh7fff, 1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sh8000_0000, 16'sh8000, 1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sh0000_0000, 16'sh0000, 1'b0);
		add_req(spq_pkg::REQ_PUSH, -32'sd1,        -16'sd1,   1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sd11,        16'sd5,    1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sd12,        16'sd5,    1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sd13,        16'sd5,    1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sd21,        16'sh8000, 1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sd22,        16'sh7fff, 1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'shaaaa_aaaa, 16'sh5555, 1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sh5555_5555, 16'shaaaa, 1'b0);
		for (int i = 0; i < 5; i++)
			add_req(spq_pkg::REQ_PUSH, 32'sd100 + i, 16'(i - 2), 1'b0);
		add_req(spq_pkg::REQ_PUSH, 32'sd999, 16'sd1, 1'b0);
		for (int i = 0; i < 6; i++)
			add_req(spq_pkg::REQ_POP, $urandom(), spq_pkg::PRIO_W'($urandom()), 1'b0);

		// Random: segments of varying push share so the list sweeps between empty and full
		for (int n = pending_reqs.size(); n < TOTAL_REQS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 3))
					0:       push_pct = 20;
					1:       push_pct = 50;
					2:       push_pct = 80;
					default: push_pct = 95;
				endcase
			end
			add_req(($urandom_range(1, 100) <= push_pct) ? spq_pkg::REQ_PUSH : spq_pkg::REQ_POP,
				$urandom(), pick_priority(), (n % 400 == 24));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!((pending_reqs.size() == 0 && !req_ch.valid && awaited_rsps.size() == 0)
				|| cycle_count >= CYCLE_LIMIT))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d requests unsent, %0d responses missing",
				cycle_count, pending_reqs.size(), awaited_rsps.size());
			$display("sorted_priority_queue_tb: done, errors");
		end else begin
			if (awaited_rsps.size() != 0)
				$display("%0d responses never arrived", awaited_rsps.size());
			$display("%0d pushes (%0d refused as full), %0d pops (%0d on empty)",
				push_count, full_count, pop_count, empty_count);
			$display("%0d responses checked, peak occupancy %0d, %0d mismatches",
				checked, peak_occ, mismatches);
			if (mismatches == 0 && awaited_rsps.size() == 0)
				$display("sorted_priority_queue_tb: done, clean");
			else
				$display("sorted_priority_queue_tb: done, errors");
		end
		$finish;
	end

endmodule
